>>> design/complementary_pulse_train_sequencer_unit_assert.svh
// Assertion macros shared by the pulse train sequencer RTL.
// Users must have signals named clock and reset in scope for CPTS_ASSERT.
`ifndef COMPLEMENTARY_PULSE_TRAIN_SEQUENCER_UNIT_ASSERT_SVH
`define COMPLEMENTARY_PULSE_TRAIN_SEQUENCER_UNIT_ASSERT_SVH

// Generic form: explicit clock and synchronous reset
`define CPTS_ASSERT_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error(msg);

// Local form: uses the module's clock and reset
`define CPTS_ASSERT(label, prop, msg) \
   `CPTS_ASSERT_CLK(label, clock, reset, prop, msg)

`endif

>>> design/cpts_pkg.sv
// Shared types and constants for the complementary pulse train sequencer.
// No dependencies.
`timescale 1ns / 1ps

package cpts_pkg;

   localparam int VALUE_W    = 32;
   localparam int DEADTIME_W = 16;
   localparam int STATUS_W   = 2;
   localparam int REQ_W      = 3;

   localparam logic [DEADTIME_W-1:0] DEADTIME_RESET = 16'd25;

   // request codes
   localparam logic [REQ_W-1:0] REQ_TICK  = 3'd0;
   localparam logic [REQ_W-1:0] REQ_ADD   = 3'd1;
   localparam logic [REQ_W-1:0] REQ_CLEAR = 3'd2;
   localparam logic [REQ_W-1:0] REQ_RUN   = 3'd3;
   localparam logic [REQ_W-1:0] REQ_RESET = 3'd4;

   // response status codes
   localparam logic [STATUS_W-1:0] STATUS_OK   = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_FULL = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_BUSY = 2'd2;

   typedef struct packed {
      logic capture;   // latch incoming request
      logic exec;      // execute latched request
      logic load;      // table word is on the RAM output
   } ctl_cmd_type;

   typedef struct packed {
      logic need_load; // execute step started an active phase
   } dp_status_type;

endpackage

>>> design/cpts_req_if.sv
// Request channel of the pulse train sequencer: valid/ready plus payload.
// Depends on cpts_pkg.
`timescale 1ns / 1ps

interface cpts_req_if import cpts_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [REQ_W-1:0]   req_type;
   logic [VALUE_W-1:0] value;

   modport source (output valid, output req_type, output value, input ready);
   modport sink   (input valid, input req_type, input value, output ready);
endinterface

>>> design/cpts_rsp_if.sv
// Response channel of the pulse train sequencer: valid/ready plus payload.
// Depends on cpts_pkg.
`timescale 1ns / 1ps

interface cpts_rsp_if import cpts_pkg::*; #(parameter int COUNT_W = 7) ();
   logic                valid;
   logic                ready;
   logic                positive_pin;
   logic                negative_pin;
   logic                busy_res;
   logic [VALUE_W-1:0]  trains_done;
   logic [COUNT_W-1:0]  pulses_stored;
   logic [STATUS_W-1:0] status;

   modport source (output valid, output positive_pin, output negative_pin,
                   output busy_res, output trains_done, output pulses_stored,
                   output status, input ready);
   modport sink   (input valid, input positive_pin, input negative_pin,
                   input busy_res, input trains_done, input pulses_stored,
                   input status, output ready);
endinterface

>>> design/cpts_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module cpts_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> design/cpts_ctrl.sv
// Sequencing controller: accepts a request, steps the datapath through
// execute and table load, and owns the response valid. Depends on cpts_pkg.
`timescale 1ns / 1ps
`include "complementary_pulse_train_sequencer_unit_assert.svh"

module cpts_ctrl import cpts_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   output logic          rsp_valid,
   input  logic          rsp_ready,
   input  dp_status_type dp_status,
   output ctl_cmd_type   cmd
);

   typedef enum logic [1:0] {
      S_IDLE,
      S_EXEC,
      S_LOAD
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   // response slot is free now or drains this cycle
   assign out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      cmd.capture = (state_ff == S_IDLE) && req_valid;
      cmd.exec    = (state_ff == S_EXEC) && out_free;
      cmd.load    = (state_ff == S_LOAD);
   end

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff;
      if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            if (out_free) begin
               if (dp_status.need_load) begin
                  state_in = S_LOAD;
               end else begin
                  state_in     = S_IDLE;
                  rsp_valid_in = 1'b1;
               end
            end
         end
         S_LOAD: begin
            state_in     = S_IDLE;
            rsp_valid_in = 1'b1;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // no request is taken while reset is held
   assign req_ready = (state_ff == S_IDLE) && !reset;
   assign rsp_valid = rsp_valid_ff;

   `CPTS_ASSERT(a_rsp_from_finish, $rose(rsp_valid_ff) |-> ($past(state_ff) == S_EXEC || $past(state_ff) == S_LOAD), "response raised outside a finishing step")
   `CPTS_ASSERT(a_load_slot_empty, (state_ff == S_LOAD) |-> !rsp_valid_ff, "table load with response slot occupied")
   `CPTS_ASSERT(a_load_after_exec, cmd.load |-> ($past(cmd.exec) && $past(dp_status.need_load)), "table load without a preceding execute")

endmodule

>>> design/cpts_dp.sv
// Datapath: request latch, deadtime register, duration table, play state
// and response registers. Depends on cpts_pkg and cpts_ram.
`timescale 1ns / 1ps

module cpts_dp import cpts_pkg::*; #(
   parameter int TABLE_DEPTH = 64
) (
   input  logic                               clock,
   input  logic                               reset,
   input  ctl_cmd_type                        cmd,
   output dp_status_type                      dp_status,
   input  logic [REQ_W-1:0]                   req_type,
   input  logic [VALUE_W-1:0]                 req_value,
   input  logic                               csr_write_enable,
   input  logic [DEADTIME_W-1:0]              csr_write_data,
   output logic                               positive_pin,
   output logic                               negative_pin,
   output logic                               busy_res,
   output logic [VALUE_W-1:0]                 trains_done,
   output logic [$clog2(TABLE_DEPTH+1)-1:0]   pulses_stored,
   output logic [STATUS_W-1:0]                status
);

   localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
   localparam int IDX_W = $clog2(TABLE_DEPTH);

   typedef enum logic [1:0] {
      PH_IDLE,
      PH_DEAD,
      PH_ACTIVE
   } phase_type;

   logic [REQ_W-1:0]      req_type_ff;
   logic [VALUE_W-1:0]    req_value_ff;
   logic [DEADTIME_W-1:0] deadtime_ff;

   logic [CNT_W-1:0]   entry_count_ff, entry_count_in;
   logic [IDX_W-1:0]   play_index_ff, play_index_in;
   phase_type          phase_ff, phase_in;
   logic [VALUE_W-1:0] ticks_left_ff, ticks_left_in;
   logic [VALUE_W-1:0] completed_ff, completed_in;
   logic [VALUE_W-1:0] target_ff, target_in;

   logic                positive_pin_ff, negative_pin_ff, busy_res_ff;
   logic [VALUE_W-1:0]  trains_done_ff;
   logic [CNT_W-1:0]    pulses_stored_ff;
   logic [STATUS_W-1:0] status_ff, status_in;

   logic               busy;
   logic               need_load;
   logic               start_entry;
   logic               ram_we;
   logic [CNT_W-1:0]   next_index;
   logic [VALUE_W-1:0] ticks_dec;
   logic [VALUE_W-1:0] dead_ext;
   logic [VALUE_W-1:0] ram_rd_data;
   logic [VALUE_W-1:0] active_ticks;

   cpts_ram #(
      .WIDTH (VALUE_W),
      .DEPTH (TABLE_DEPTH)
   ) u_table (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (entry_count_ff[IDX_W-1:0]),
      .wr_data (req_value_ff),
      .rd_en   (need_load),
      .rd_addr (play_index_in),
      .rd_data (ram_rd_data)
   );

   assign busy       = (phase_ff != PH_IDLE);
   assign dead_ext   = {{(VALUE_W-DEADTIME_W){1'b0}}, deadtime_ff};
   assign next_index = CNT_W'(play_index_ff) + CNT_W'(1);
   assign ticks_dec  = (ticks_left_ff != '0) ? ticks_left_ff - VALUE_W'(1) : '0;
   // active phase length once the dead interval is taken out, at least one tick
   assign active_ticks = (ram_rd_data > dead_ext) ? ram_rd_data - dead_ext
                                                  : VALUE_W'(1);

   always_comb begin
      entry_count_in = entry_count_ff;
      play_index_in  = play_index_ff;
      phase_in       = phase_ff;
      ticks_left_in  = ticks_left_ff;
      completed_in   = completed_ff;
      target_in      = target_ff;
      status_in      = STATUS_OK;
      need_load      = 1'b0;
      start_entry    = 1'b0;
      ram_we         = 1'b0;

      if (cmd.exec) begin
         case (req_type_ff)
            REQ_TICK: begin
               if (busy) begin
                  ticks_left_in = ticks_dec;
                  if (ticks_dec == '0) begin
                     if (phase_ff == PH_DEAD) begin
                        need_load = 1'b1;
                     end else if (next_index < entry_count_ff) begin
                        play_index_in = next_index[IDX_W-1:0];
                        start_entry   = 1'b1;
                     end else begin
                        completed_in  = completed_ff + VALUE_W'(1);
                        play_index_in = '0;
                        if (completed_in == target_ff) begin
                           phase_in      = PH_IDLE;
                           ticks_left_in = '0;
                        end else begin
                           start_entry = 1'b1;
                        end
                     end
                  end
               end
            end
            REQ_ADD: begin
               if (busy) begin
                  status_in = STATUS_BUSY;
               end else if (entry_count_ff == CNT_W'(TABLE_DEPTH)) begin
                  status_in = STATUS_FULL;
               end else begin
                  ram_we         = 1'b1;
                  entry_count_in = entry_count_ff + CNT_W'(1);
               end
            end
            REQ_CLEAR: begin
               if (busy) begin
                  status_in = STATUS_BUSY;
               end else begin
                  entry_count_in = '0;
               end
            end
            REQ_RUN: begin
               if (busy) begin
                  status_in = STATUS_BUSY;
               end else if (req_value_ff != '0) begin
                  if (entry_count_ff == '0) begin
                     completed_in = completed_ff + req_value_ff;
                  end else begin
                     target_in     = completed_ff + req_value_ff;
                     play_index_in = '0;
                     start_entry   = 1'b1;
                  end
               end
            end
            REQ_RESET: begin
               entry_count_in = '0;
               play_index_in  = '0;
               phase_in       = PH_IDLE;
               ticks_left_in  = '0;
               completed_in   = '0;
               target_in      = '0;
            end
            default: begin
            end
         endcase

         if (start_entry) begin
            if (deadtime_ff != '0) begin
               phase_in      = PH_DEAD;
               ticks_left_in = dead_ext;
            end else begin
               need_load = 1'b1;
            end
         end
      end

      if (cmd.load) begin
         phase_in      = PH_ACTIVE;
         ticks_left_in = active_ticks;
      end
   end

   assign dp_status.need_load = need_load;

   always_ff @(posedge clock) begin
      if (reset) begin
         deadtime_ff    <= DEADTIME_RESET;
         entry_count_ff <= '0;
         play_index_ff  <= '0;
         phase_ff       <= PH_IDLE;
         ticks_left_ff  <= '0;
         completed_ff   <= '0;
         target_ff      <= '0;
      end else begin
         if (csr_write_enable) begin
            deadtime_ff <= csr_write_data;
         end
         entry_count_ff <= entry_count_in;
         play_index_ff  <= play_index_in;
         phase_ff       <= phase_in;
         ticks_left_ff  <= ticks_left_in;
         completed_ff   <= completed_in;
         target_ff      <= target_in;
      end
   end

   // request latch and response payload
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         req_type_ff  <= req_type;
         req_value_ff <= req_value;
      end
      if (cmd.exec || cmd.load) begin
         positive_pin_ff  <= (phase_in == PH_ACTIVE) && !play_index_in[0];
         negative_pin_ff  <= (phase_in == PH_ACTIVE) && play_index_in[0];
         busy_res_ff      <= (phase_in != PH_IDLE);
         trains_done_ff   <= completed_in;
         pulses_stored_ff <= entry_count_in;
      end
      if (cmd.exec) begin
         status_ff <= status_in;
      end
   end

   assign positive_pin  = positive_pin_ff;
   assign negative_pin  = negative_pin_ff;
   assign busy_res      = busy_res_ff;
   assign trains_done   = trains_done_ff;
   assign pulses_stored = pulses_stored_ff;
   assign status        = status_ff;

endmodule

>>> design/complementary_pulse_train_sequencer_unit.sv
// Complementary pulse train sequencer with deadtime: top level.
// Depends on cpts_pkg, cpts_req_if, cpts_rsp_if, cpts_ctrl, cpts_dp.
//
// req_bus carries one request (tick, add pulse, clear, run, reset) with a
// 32-bit value; rsp_bus returns exactly one response per request holding
// the pin levels, busy flag, trains done, table fill and a status code.
// csr_write_enable/csr_write_data load the 16-bit deadtime; write it only
// while no request is in flight.
// The response is registered by the execute step once the response slot is
// free, or by the table load step that follows when the request begins an
// active phase, since the pulse duration comes through the registered read
// port of the table RAM. Each request finishes before the next is accepted,
// which can be as soon as its response is registered, before it is taken.
// A tick request is one tick of pulse timing.
// Reset: clears the play state, empties the table and sets the deadtime to
// 25; ready stays low while reset is high. The table RAM is not cleared;
// entries past the fill are never read.
// Stalls: a response waits in its output register while rsp_bus.ready is
// low; the next request may be accepted meanwhile but holds in execute
// until the response register drains.
`timescale 1ns / 1ps

module complementary_pulse_train_sequencer_unit import cpts_pkg::*; #(
   parameter int TABLE_DEPTH = 64
) (
   input  logic                  clock,
   input  logic                  reset,
   cpts_req_if.sink              req_bus,
   cpts_rsp_if.source            rsp_bus,
   input  logic                  csr_write_enable,
   input  logic [DEADTIME_W-1:0] csr_write_data
);

   ctl_cmd_type   cmd;
   dp_status_type dp_status;

   cpts_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_bus.ready),
      .rsp_valid (rsp_bus.valid),
      .rsp_ready (rsp_bus.ready),
      .dp_status (dp_status),
      .cmd       (cmd)
   );

   cpts_dp #(
      .TABLE_DEPTH (TABLE_DEPTH)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .dp_status        (dp_status),
      .req_type         (req_bus.req_type),
      .req_value        (req_bus.value),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .positive_pin     (rsp_bus.positive_pin),
      .negative_pin     (rsp_bus.negative_pin),
      .busy_res         (rsp_bus.busy_res),
      .trains_done      (rsp_bus.trains_done),
      .pulses_stored    (rsp_bus.pulses_stored),
      .status           (rsp_bus.status)
   );

endmodule
